// File: hw/rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// shared types and codes for the timer bank
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_MAKE  = 3'd1;
   localparam logic [2:0] OP_PAUSE = 3'd2;
   localparam logic [2:0] OP_STOP  = 3'd3;
   localparam logic [2:0] OP_START = 3'd4;
   localparam logic [2:0] OP_REMOVE = 3'd5;
   localparam logic [2:0] OP_SETIV = 3'd6;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam logic [1:0] KIND_FIRED = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ALLOC = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // one classified command handed from front to back
   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  timer_id;
      logic [30:0] period;
      logic        app_clock;
      logic [23:0] elapsed;
      logic [15:0] time_scale;
   } cmd_type;

endpackage

// File: hw/rtl/software_timer_bank.sv
// ----------------------------------------------------------------------------
// software_timer_bank
// bank of repeating countdown timers with slot allocation
// ----------------------------------------------------------------------------
//  channel  ports                          handshake
//  request  req_op .. req_time_scale       start & !busy
//  result   rsp_kind rsp_slot rsp_last     rsp_valid, one cycle
//
//  a tick passes through the scale product, the slot walk over every slot and the
//  closing beat in turn; other commands go from capture straight to their result.
//  a two-entry queue takes commands while the back end works; busy means full.
//  reset is synchronous and clears every timer; the receiver cannot stall.
// ----------------------------------------------------------------------------
module software_timer_bank
   import stb_pkg::*;
#(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_timer_id,
   input  logic [30:0] req_period,
   input  logic        req_app_clock,
   input  logic [23:0] req_elapsed,
   input  logic [15:0] req_time_scale,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_slot,
   output logic        rsp_last
);

   cmd_type in_cmd, head_cmd;
   logic    full, avail, pop, push;

   assign busy   = full;
   assign push   = start && !full;
   assign in_cmd = '{op: req_op, timer_id: req_timer_id, period: req_period,
                     app_clock: req_app_clock, elapsed: req_elapsed,
                     time_scale: req_time_scale};

   stb_front u_front (
      .clock(clock), .reset(reset), .push(push), .push_cmd(in_cmd), .full(full),
      .pop(pop), .avail(avail), .head_cmd(head_cmd)
   );

   stb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock(clock), .reset(reset), .avail(avail), .cmd(head_cmd), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_slot(rsp_slot),
      .rsp_last(rsp_last)
   );

   // a fired beat is never the closing one
   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FIRED |-> !rsp_last) else $error("fired beat marked last");

   // an allocation or error closes its command
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ALLOC || rsp_kind == KIND_ERROR) |-> rsp_last)
      else $error("single beat not last");

   // beats after a closing beat need a fresh command from the queue
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid) else $error("beat right after closing beat");

endmodule

// File: hw/rtl/stb_front.sv
// ----------------------------------------------------------------------------
// stb_front
// accepts commands into a two-entry queue for the back end
// ----------------------------------------------------------------------------
module stb_front
   import stb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  cmd_type     push_cmd,
   output logic        full,
   input  logic        pop,
   output logic        avail,
   output cmd_type     head_cmd
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign avail    = cnt_ff != 2'd0;
   assign head_cmd = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) q_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// File: hw/rtl/stb_back.sv
// ----------------------------------------------------------------------------
// stb_back
// carries out commands on the timer state, one slot per cycle for a tick
// ----------------------------------------------------------------------------
module stb_back
   import stb_pkg::*;
#(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        avail,
   input  cmd_type     cmd,
   output logic        pop,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_slot,
   output logic        rsp_last
);

   localparam int IW = $clog2(NUM_TIMERS);
   localparam int CW = $clog2(NUM_TIMERS + 1);

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_TICK, S_DONE, S_OP} state_type;

   state_type      state_ff;
   cmd_type        cur_ff;
   logic [31:0]    remaining_ff [NUM_TIMERS];
   logic [30:0]    interval_ff  [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] running_ff, in_use_ff, unscaled_ff;
   // links carry the empty marker too
   logic [CW-1:0]  free_link_ff [NUM_TIMERS];
   logic [CW-1:0]  free_head_ff, high_water_ff;
   logic [31:0]    scaled_ff;
   logic [CW-1:0]  idx_ff;
   logic           rsp_valid_ff;
   logic [1:0]     rsp_kind_ff;
   logic [3:0]     rsp_slot_ff;
   logic           rsp_last_ff;

   // tick datapath for the visited slot
   logic [IW-1:0]  ti;
   logic [32:0]    dec;
   logic signed [33:0] diff;
   logic [31:0]    sat_sub;
   logic           fire;
   logic [39:0]    prod;
   // targeted ops
   logic [IW-1:0]  tid;
   logic           bad_id;
   logic signed [33:0] sum_iv;
   logic [31:0]    sat_add;

   assign prod = cur_ff.elapsed * cur_ff.time_scale;
   assign ti   = idx_ff[IW-1:0];
   assign dec  = unscaled_ff[ti] ? {9'd0, cur_ff.elapsed} : {1'b0, scaled_ff};
   assign diff = $signed({{2{remaining_ff[ti][31]}}, remaining_ff[ti]})
               - $signed({1'b0, dec});
   always_comb begin
      if (diff > 34'sh0_7FFF_FFFF)       sat_sub = 32'h7FFF_FFFF;
      else if (diff < -34'sh0_8000_0000) sat_sub = 32'h8000_0000;
      else                               sat_sub = diff[31:0];
   end
   assign fire = $signed(sat_sub) <= 0;

   assign tid    = IW'(cur_ff.timer_id);
   assign bad_id = ({2'b0, cur_ff.timer_id} >= 6'(NUM_TIMERS)) || !in_use_ff[tid];
   assign sum_iv = $signed({{2{remaining_ff[tid][31]}}, remaining_ff[tid]})
                 + $signed({3'b0, cur_ff.period}) - $signed({3'b0, interval_ff[tid]});
   always_comb begin
      if (sum_iv > 34'sh0_7FFF_FFFF)       sat_add = 32'h7FFF_FFFF;
      else if (sum_iv < -34'sh0_8000_0000) sat_add = 32'h8000_0000;
      else                                 sat_add = sum_iv[31:0];
   end

   assign pop       = state_ff == S_IDLE && avail;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_last  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         running_ff    <= '0;
         in_use_ff     <= '0;
         unscaled_ff   <= '0;
         free_head_ff  <= CW'(NUM_TIMERS);
         high_water_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            remaining_ff[i] <= '0;
            interval_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (avail) begin
                  cur_ff   <= cmd;
                  idx_ff   <= '0;
                  state_ff <= (cmd.op == OP_TICK) ? S_MUL : S_OP;
               end
            end
            S_MUL: begin
               scaled_ff <= (prod[39:8] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : prod[39:8];
               state_ff  <= S_TICK;
            end
            S_TICK: begin
               if (in_use_ff[ti] && running_ff[ti]) begin
                  if (fire) begin
                     remaining_ff[ti] <= {1'b0, interval_ff[ti]};
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff  <= KIND_FIRED;
                     rsp_slot_ff  <= 4'(idx_ff);
                     rsp_last_ff  <= 1'b0;
                  end else begin
                     remaining_ff[ti] <= sat_sub;
                  end
               end
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == CW'(NUM_TIMERS - 1)) state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= KIND_DONE;
               rsp_slot_ff  <= '0;
               rsp_last_ff  <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_OP: begin
               rsp_valid_ff <= 1'b1;
               rsp_last_ff  <= 1'b1;
               state_ff     <= S_IDLE;
               if (cur_ff.op == OP_MAKE) begin
                  if (free_head_ff < CW'(NUM_TIMERS) || high_water_ff < CW'(NUM_TIMERS)) begin
                     logic [IW-1:0] s;
                     if (free_head_ff < CW'(NUM_TIMERS)) begin
                        s = free_head_ff[IW-1:0];
                        free_head_ff <= free_link_ff[s];
                     end else begin
                        s = high_water_ff[IW-1:0];
                        high_water_ff <= high_water_ff + 1'b1;
                     end
                     remaining_ff[s] <= {1'b0, cur_ff.period};
                     interval_ff[s]  <= cur_ff.period;
                     running_ff[s]   <= 1'b1;
                     in_use_ff[s]    <= 1'b1;
                     unscaled_ff[s]  <= cur_ff.app_clock;
                     rsp_kind_ff <= KIND_ALLOC;
                     rsp_slot_ff <= 4'(s);
                  end else begin
                     rsp_kind_ff <= KIND_ERROR;
                     rsp_slot_ff <= '0;
                  end
               end else if (cur_ff.op == OP_UNUSED || bad_id) begin
                  rsp_kind_ff <= KIND_ERROR;
                  rsp_slot_ff <= cur_ff.timer_id;
               end else begin
                  rsp_kind_ff <= KIND_DONE;
                  rsp_slot_ff <= cur_ff.timer_id;
                  case (cur_ff.op)
                     OP_PAUSE: running_ff[tid] <= 1'b0;
                     OP_STOP: begin
                        if (running_ff[tid]) begin
                           running_ff[tid]   <= 1'b0;
                           remaining_ff[tid] <= {1'b0, interval_ff[tid]};
                        end
                     end
                     OP_START: running_ff[tid] <= 1'b1;
                     OP_REMOVE: begin
                        running_ff[tid]   <= 1'b0;
                        in_use_ff[tid]    <= 1'b0;
                        free_link_ff[tid] <= free_head_ff;
                        free_head_ff      <= CW'(tid);
                     end
                     default: begin
                        remaining_ff[tid] <= sat_add;
                        interval_ff[tid]  <= cur_ff.period;
                     end
                  endcase
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the timer bank: a directed table of commands
// followed by random command mixes, every result beat checked in order
// against a behavioral model of the bank
// ----------------------------------------------------------------------------
module testbench;
   import stb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NT = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 426;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  timer_id;
      logic [30:0] period;
      logic        app_clock;
      logic [23:0] elapsed;
      logic [15:0] time_scale;
   } command_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] slot;
      logic       last;
   } beat_type;

   // directed row: command plus optional typed-in answer
   typedef struct {
      command_type cmd;
      logic        known;
      logic [1:0]  kind;
      logic [3:0]  slot;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_op = '0;
   logic [3:0]  req_timer_id = '0;
   logic [30:0] req_period = '0;
   logic        req_app_clock = 1'b0;
   logic [23:0] req_elapsed = '0;
   logic [15:0] req_time_scale = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_slot;
   logic        rsp_last;

   software_timer_bank #(.NUM_TIMERS(NT)) dut (.*);

   always #10 clock = ~clock;

   // model state
   logic signed [31:0] m_remaining [NT];
   logic [30:0]        m_interval [NT];
   logic               m_running [NT];
   logic               m_in_use [NT];
   logic               m_unscaled [NT];
   int                 m_free_link [NT];
   int                 m_free_head;
   int                 m_high_water;

   beat_type pending_beats [$];
   int    failures = 0;
   int    beats_checked = 0;
   int    fired_seen = 0;
   int    idle_cycles = 0;
   int    items_sent = 0;
   logic  quiet = 1'b0;

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic void push_beat(logic [1:0] k, logic [3:0] s, logic l);
      beat_type b;
      b.kind = k;
      b.slot = s;
      b.last = l;
      pending_beats.push_back(b);
   endfunction

   function automatic void model_reset();
      for (int i = 0; i < NT; i++) begin
         m_remaining[i] = '0;
         m_interval[i] = '0;
         m_running[i] = 1'b0;
         m_in_use[i] = 1'b0;
         m_unscaled[i] = 1'b0;
         m_free_link[i] = 0;
      end
      m_free_head = NT;
      m_high_water = 0;
   endfunction

   // predict the beats a command causes and advance the model
   function automatic void predict_timer_beats(command_type c);
      longint sdt, scaled, dec;
      int slot_idx;
      int id;
      id = c.timer_id;
      if (c.op == OP_TICK) begin
         sdt = (longint'(c.elapsed) * longint'(c.time_scale)) >>> 8;
         scaled = (sdt > 64'sh7fffffff) ? 64'sh7fffffff : sdt;
         for (int i = 0; i < NT; i++) begin
            if (m_in_use[i] && m_running[i]) begin
               dec = m_unscaled[i] ? longint'(c.elapsed) : scaled;
               m_remaining[i] = clamp32(longint'(m_remaining[i]) - dec);
               if (m_remaining[i] <= 0) begin
                  push_beat(KIND_FIRED, 4'(i), 1'b0);
                  m_remaining[i] = {1'b0, m_interval[i]};
               end
            end
         end
         push_beat(KIND_DONE, 4'd0, 1'b1);
      end else if (c.op == OP_MAKE) begin
         if (m_free_head < NT) begin
            slot_idx = m_free_head;
            m_free_head = m_free_link[slot_idx];
         end else if (m_high_water < NT) begin
            slot_idx = m_high_water;
            m_high_water++;
         end else begin
            push_beat(KIND_ERROR, 4'd0, 1'b1);
            return;
         end
         m_remaining[slot_idx] = {1'b0, c.period};
         m_interval[slot_idx] = c.period;
         m_running[slot_idx] = 1'b1;
         m_in_use[slot_idx] = 1'b1;
         m_unscaled[slot_idx] = c.app_clock;
         push_beat(KIND_ALLOC, 4'(slot_idx), 1'b1);
      end else if (c.op == OP_UNUSED || id >= NT || !m_in_use[id]) begin
         push_beat(KIND_ERROR, c.timer_id, 1'b1);
      end else begin
         case (c.op)
            OP_PAUSE: m_running[id] = 1'b0;
            OP_STOP: begin
               if (m_running[id]) begin
                  m_running[id] = 1'b0;
                  m_remaining[id] = {1'b0, m_interval[id]};
               end
            end
            OP_START: m_running[id] = 1'b1;
            OP_REMOVE: begin
               m_running[id] = 1'b0;
               m_in_use[id] = 1'b0;
               m_free_link[id] = m_free_head;
               m_free_head = id;
            end
            default: begin
               m_remaining[id] = clamp32(longint'(m_remaining[id]) + longint'(c.period)
                                         - longint'(m_interval[id]));
               m_interval[id] = c.period;
            end
         endcase
         push_beat(KIND_DONE, c.timer_id, 1'b1);
      end
   endfunction

   // result checker, sampled at the edge that accepts the beat
   always @(posedge clock) begin
      beat_type exp_b;
      if (!reset && rsp_valid) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected beat kind=%0d slot=%0d last=%0d", rsp_kind, rsp_slot, rsp_last);
            failures++;
         end else begin
            exp_b = pending_beats.pop_front();
            beats_checked++;
            if (rsp_kind == KIND_FIRED) fired_seen++;
            if (rsp_kind !== exp_b.kind) begin
               $error("kind: expected %0d actual %0d", exp_b.kind, rsp_kind);
               failures++;
            end
            if (rsp_slot !== exp_b.slot) begin
               $error("slot: expected %0d actual %0d", exp_b.slot, rsp_slot);
               failures++;
            end
            if (rsp_last !== exp_b.last) begin
               $error("last: expected %0d actual %0d", exp_b.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted beat on either side
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d beats still pending", pending_beats.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic command_type make_cmd(logic [2:0] op, logic [3:0] id, logic [30:0] per,
                                            logic app, logic [23:0] el, logic [15:0] sc);
      command_type c;
      c.op = op;
      c.timer_id = id;
      c.period = per;
      c.app_clock = app;
      c.elapsed = el;
      c.time_scale = sc;
      return c;
   endfunction

   // drive one command and hold it until accepted
   task automatic send_command(command_type c, logic known, logic [1:0] k, logic [3:0] s);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= c.op;
      req_timer_id <= c.timer_id;
      req_period <= c.period;
      req_app_clock <= c.app_clock;
      req_elapsed <= c.elapsed;
      req_time_scale <= c.time_scale;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (known && (c.op != OP_TICK)) begin
         // typed-in answer cross-checks the model before the beat arrives
         predict_timer_beats(c);
         if (pending_beats[$].kind !== k || pending_beats[$].slot !== s) begin
            $error("directed row: model gives kind %0d slot %0d, table %0d %0d",
                   pending_beats[$].kind, pending_beats[$].slot, k, s);
            failures++;
         end
      end else begin
         predict_timer_beats(c);
      end
      items_sent++;
   endtask

   function automatic command_type random_command();
      command_type c;
      int r;
      c = make_cmd(3'($urandom_range(0, 7)), 4'($urandom), 31'($urandom), 1'($urandom),
                   24'($urandom), 16'($urandom));
      // keep periods mostly short so timers fire often
      r = $urandom_range(0, 9);
      if (r < 6) c.period = 31'($urandom_range(1, 32'h0008_0000));
      else if (r == 6) c.period = '0;
      else if (r == 7) c.period = 31'h7fffffff;
      r = $urandom_range(0, 9);
      if (r < 6) c.elapsed = 24'($urandom_range(0, 24'h02_0000));
      r = $urandom_range(0, 9);
      if (r < 5) c.time_scale = 16'($urandom_range(0, 16'h0200));
      // weight toward valid ids and useful ops
      r = $urandom_range(0, 19);
      if (r < 6) c.op = OP_TICK;
      else if (r < 10) c.op = OP_MAKE;
      else if (r < 19) c.op = 3'($urandom_range(2, 6));
      if ($urandom_range(0, 9) < 8 && m_high_water > 0)
         c.timer_id = 4'($urandom_range(0, m_high_water - 1));
      return c;
   endfunction

   row_type directed_rows [$];

   initial begin
      command_type c;
      row_type r;
      model_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // build directed table
      directed_rows.push_back('{make_cmd(OP_PAUSE, 4'd0, '0, 1'b0, '0, '0), 1'b1, KIND_ERROR, 4'd0});
      directed_rows.push_back('{make_cmd(OP_UNUSED, 4'd15, '0, 1'b0, '0, '0), 1'b1, KIND_ERROR, 4'd15});
      directed_rows.push_back('{make_cmd(OP_TICK, 4'd0, '0, 1'b0, 24'hffffff, 16'hffff), 1'b0, '0, '0});
      for (int i = 0; i < NT; i++)
         directed_rows.push_back('{make_cmd(OP_MAKE, 4'd0, (i == 0) ? 31'h7fffffff : 31'(i * 4096),
                                            1'(i % 2), '0, '0), 1'b1, KIND_ALLOC, 4'(i)});
      directed_rows.push_back('{make_cmd(OP_MAKE, 4'd0, 31'd1, 1'b0, '0, '0), 1'b1, KIND_ERROR, 4'd0});
      directed_rows.push_back('{make_cmd(OP_TICK, 4'd0, '0, 1'b0, 24'hffffff, 16'hffff), 1'b0, '0, '0});
      directed_rows.push_back('{make_cmd(OP_TICK, 4'd0, '0, 1'b0, 24'h000001, 16'h0000), 1'b0, '0, '0});
      directed_rows.push_back('{make_cmd(OP_PAUSE, 4'd3, '0, 1'b0, '0, '0), 1'b1, KIND_DONE, 4'd3});
      directed_rows.push_back('{make_cmd(OP_STOP, 4'd3, '0, 1'b0, '0, '0), 1'b1, KIND_DONE, 4'd3});
      directed_rows.push_back('{make_cmd(OP_STOP, 4'd4, '0, 1'b0, '0, '0), 1'b1, KIND_DONE, 4'd4});
      directed_rows.push_back('{make_cmd(OP_START, 4'd3, '0, 1'b0, '0, '0), 1'b1, KIND_DONE, 4'd3});
      directed_rows.push_back('{make_cmd(OP_SETIV, 4'd0, '0, 1'b0, '0, '0), 1'b1, KIND_DONE, 4'd0});
      directed_rows.push_back('{make_cmd(OP_SETIV, 4'd1, 31'h7fffffff, 1'b0, '0, '0), 1'b1, KIND_DONE, 4'd1});
      directed_rows.push_back('{make_cmd(OP_REMOVE, 4'd5, '0, 1'b0, '0, '0), 1'b1, KIND_DONE, 4'd5});
      directed_rows.push_back('{make_cmd(OP_REMOVE, 4'd5, '0, 1'b0, '0, '0), 1'b1, KIND_ERROR, 4'd5});
      directed_rows.push_back('{make_cmd(OP_REMOVE, 4'd9, '0, 1'b0, '0, '0), 1'b1, KIND_DONE, 4'd9});
      directed_rows.push_back('{make_cmd(OP_MAKE, 4'd0, 31'd100, 1'b1, '0, '0), 1'b1, KIND_ALLOC, 4'd9});
      directed_rows.push_back('{make_cmd(OP_MAKE, 4'd0, 31'd200, 1'b0, '0, '0), 1'b1, KIND_ALLOC, 4'd5});
      directed_rows.push_back('{make_cmd(OP_MAKE, 4'd0, 31'd300, 1'b0, '0, '0), 1'b1, KIND_ERROR, 4'd0});
      directed_rows.push_back('{make_cmd(OP_TICK, 4'd0, '0, 1'b1, 24'h010000, 16'h0100), 1'b0, '0, '0});

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         send_command(r.cmd, r.known, r.kind, r.slot);
      end

      // random part, quiet at the end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= RANDOM_ITEMS - 60);
         c = random_command();
         send_command(c, 1'b0, '0, '0);
      end
      start <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (2 * NT + 10) @(posedge clock);

      $display("ran %0d commands, checked %0d result beats including %0d timer firings",
               items_sent, beats_checked, fired_seen);
      if (failures == 0 && pending_beats.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
